/* design/dtq_pkg.sv */
// Shared types, widths and codes of the deadline timer queue.
package dtq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int MAX_RESULTS  = 16;

   localparam int KIND_W = 2;
   localparam int ID_W   = 32;
   localparam int DL_W   = 48;
   localparam int PER_W  = 32;
   localparam int RES_W  = 3;

   localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd3;

   localparam logic [RES_W-1:0] RES_DONE      = 3'd0;
   localparam logic [RES_W-1:0] RES_FIRED     = 3'd1;
   localparam logic [RES_W-1:0] RES_FULL      = 3'd2;
   localparam logic [RES_W-1:0] RES_NOT_FOUND = 3'd3;
   localparam logic [RES_W-1:0] RES_NONE_DUE  = 3'd4;

   typedef struct packed {
      logic [DL_W-1:0]  deadline;
      logic [ID_W-1:0]  id;
      logic [PER_W-1:0] period;
   } slot_type;

endpackage

/* design/dtq_if.sv */
// Request and response channel interfaces of the deadline timer queue.
interface dtq_req_if;
   logic                         valid;
   logic                         ready;
   logic [dtq_pkg::KIND_W-1:0]   kind;
   logic [dtq_pkg::ID_W-1:0]     tmr_id;
   logic [dtq_pkg::DL_W-1:0]     deadline;
   logic [dtq_pkg::PER_W-1:0]    repeat_period;
   logic [dtq_pkg::DL_W-1:0]     now;

   modport source (output valid, kind, tmr_id, deadline, repeat_period, now, input ready);
   modport sink   (input valid, kind, tmr_id, deadline, repeat_period, now, output ready);
endinterface

interface dtq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dtq_pkg::RES_W-1:0]    event_res;
   logic [dtq_pkg::ID_W-1:0]     fired_id;
   logic                         next_valid;
   logic [dtq_pkg::DL_W-1:0]     next_deadline;
   logic                         last;

   modport source (output valid, event_res, fired_id, next_valid, next_deadline, last,
                   input ready);
   modport sink   (input valid, event_res, fired_id, next_valid, next_deadline, last,
                   output ready);
endinterface

/* design/dtq_slot_ram.sv */
// Timer slot memory: one write port, one read port, registered read data.
module dtq_slot_ram #(
   parameter int CAPACITY = dtq_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [$clog2(CAPACITY)-1:0] waddr,
   input  dtq_pkg::slot_type           wdata,
   input  logic                        re,
   input  logic [$clog2(CAPACITY)-1:0] raddr,
   output dtq_pkg::slot_type           rdata
);

   dtq_pkg::slot_type mem_ff [CAPACITY];
   dtq_pkg::slot_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/dtq_ctrl.sv */
// Sequencer: scans, shifts and inserts slots in the memory and drives responses.
module dtq_ctrl #(
   parameter int CAPACITY = dtq_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   dtq_req_if.sink                     req_bus,
   dtq_rsp_if.source                   rsp_bus,
   output logic                        mem_we,
   output logic [$clog2(CAPACITY)-1:0] mem_waddr,
   output dtq_pkg::slot_type           mem_wdata,
   output logic                        mem_re,
   output logic [$clog2(CAPACITY)-1:0] mem_raddr,
   input  dtq_pkg::slot_type           mem_rdata
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int KW   = $clog2(dtq_pkg::MAX_RESULTS + 1);
   localparam int SW   = (CW > KW) ? CW : KW;
   localparam int DL_W = dtq_pkg::DL_W;
   localparam int EXT  = DL_W - dtq_pkg::PER_W + 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FIND    = 3'd1;
   localparam logic [2:0] S_DROP    = 3'd2;
   localparam logic [2:0] S_PLACE   = 3'd3;
   localparam logic [2:0] S_HEAD_RD = 3'd4;
   localparam logic [2:0] S_HEAD_EV = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 ptr_ff, ptr_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                 rd_addr_ff, rd_addr_in;
   logic [dtq_pkg::RES_W-1:0]     code_ff, code_in;
   logic                          is_adv_ff, is_adv_in;
   logic                          place_pend_ff, place_pend_in;
   logic [DL_W-1:0]               now_ff, now_in;
   logic [DL_W-1:0]               new_dl_ff, new_dl_in;
   logic [dtq_pkg::ID_W-1:0]      new_id_ff, new_id_in;
   logic [dtq_pkg::PER_W-1:0]     new_per_ff, new_per_in;
   logic [KW-1:0]                 k_ff, k_in;
   logic [CW-1:0]                 nstart_ff, nstart_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dtq_pkg::RES_W-1:0]     rsp_res_ff;
   logic [dtq_pkg::ID_W-1:0]      rsp_id_ff;
   logic                          rsp_nv_ff;
   logic [DL_W-1:0]               rsp_nd_ff;
   logic                          rsp_last_ff;

   logic                          emit;
   logic [dtq_pkg::RES_W-1:0]     e_res;
   logic [dtq_pkg::ID_W-1:0]      e_id;
   logic                          e_last;
   logic                          can_emit;
   logic                          head_valid;
   logic [DL_W-1:0]               head_dl;
   logic                          fire_next;
   logic [DL_W:0]                 rearm_sum;
   logic [DL_W-1:0]               rearm_dl;
   dtq_pkg::slot_type             new_slot;

   assign can_emit   = !rsp_valid_ff || rsp_bus.ready;
   assign head_valid = (cnt_ff != '0);
   assign head_dl    = head_valid ? mem_rdata.deadline : '0;
   assign rearm_sum  = {1'b0, now_ff} + {{EXT{1'b0}}, mem_rdata.period};
   assign rearm_dl   = rearm_sum[DL_W] ? {DL_W{1'b1}} : rearm_sum[DL_W-1:0];
   assign fire_next  = head_valid
                       && (SW'(k_ff) < SW'(dtq_pkg::MAX_RESULTS))
                       && (SW'(k_ff) < SW'(nstart_ff))
                       && (mem_rdata.deadline <= now_ff);
   assign new_slot   = '{deadline: new_dl_ff, id: new_id_ff, period: new_per_ff};

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = 1'b0;
      rd_addr_in    = rd_addr_ff;
      code_in       = code_ff;
      is_adv_in     = is_adv_ff;
      place_pend_in = place_pend_ff;
      now_in        = now_ff;
      new_dl_in     = new_dl_ff;
      new_id_in     = new_id_ff;
      new_per_in    = new_per_ff;
      k_in          = k_ff;
      nstart_in     = nstart_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      emit          = 1'b0;
      e_res         = dtq_pkg::RES_DONE;
      e_id          = new_id_ff;
      e_last        = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               new_dl_in     = req_bus.deadline;
               new_id_in     = req_bus.tmr_id;
               new_per_in    = req_bus.repeat_period;
               now_in        = req_bus.now;
               is_adv_in     = 1'b0;
               place_pend_in = 1'b0;
               k_in          = '0;
               nstart_in     = cnt_ff;
               unique case (req_bus.kind)
                  dtq_pkg::KIND_ADD: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        code_in  = dtq_pkg::RES_FULL;
                        state_in = S_HEAD_RD;
                     end else begin
                        code_in  = dtq_pkg::RES_DONE;
                        ptr_in   = cnt_ff;
                        state_in = S_PLACE;
                     end
                  end
                  dtq_pkg::KIND_CANCEL, dtq_pkg::KIND_UPDATE: begin
                     code_in       = dtq_pkg::RES_NOT_FOUND;
                     place_pend_in = (req_bus.kind == dtq_pkg::KIND_UPDATE);
                     ptr_in        = '0;
                     state_in      = (cnt_ff == '0) ? S_HEAD_RD : S_FIND;
                  end
                  dtq_pkg::KIND_ADVANCE: begin
                     is_adv_in = 1'b1;
                     state_in  = S_HEAD_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FIND: begin
            if (rd_vld_ff && (mem_rdata.id == new_id_ff)) begin
               code_in  = dtq_pkg::RES_DONE;
               ptr_in   = CW'(rd_addr_ff) + 1'b1;
               state_in = S_DROP;
            end else if (rd_vld_ff && (CW'(rd_addr_ff) == cnt_ff - 1'b1)) begin
               state_in = S_HEAD_RD;
            end else if (ptr_ff < cnt_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = ptr_ff[AW-1:0];
               rd_vld_in  = 1'b1;
               rd_addr_in = ptr_ff[AW-1:0];
               ptr_in     = ptr_ff + 1'b1;
            end
         end
         S_DROP: begin
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff - 1'b1;
               mem_wdata = mem_rdata;
            end
            if (ptr_ff < cnt_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = ptr_ff[AW-1:0];
               rd_vld_in  = 1'b1;
               rd_addr_in = ptr_ff[AW-1:0];
               ptr_in     = ptr_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               cnt_in = cnt_ff - 1'b1;
               if (place_pend_ff) begin
                  place_pend_in = 1'b0;
                  ptr_in        = cnt_ff - 1'b1;
                  state_in      = S_PLACE;
               end else begin
                  state_in = S_HEAD_RD;
               end
            end
         end
         S_PLACE: begin
            // walk down from the top, moving later deadlines up one slot
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff + 1'b1;
               if (mem_rdata.deadline > new_dl_ff) begin
                  mem_wdata = mem_rdata;
                  if (ptr_ff != '0) begin
                     mem_re     = 1'b1;
                     mem_raddr  = AW'(ptr_ff - 1'b1);
                     rd_vld_in  = 1'b1;
                     rd_addr_in = AW'(ptr_ff - 1'b1);
                     ptr_in     = ptr_ff - 1'b1;
                  end
               end else begin
                  mem_wdata = new_slot;
                  cnt_in    = cnt_ff + 1'b1;
                  state_in  = S_HEAD_RD;
               end
            end else if (ptr_ff != '0) begin
               mem_re     = 1'b1;
               mem_raddr  = AW'(ptr_ff - 1'b1);
               rd_vld_in  = 1'b1;
               rd_addr_in = AW'(ptr_ff - 1'b1);
               ptr_in     = ptr_ff - 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = new_slot;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = S_HEAD_EV;
         end
         S_HEAD_EV: begin
            if (can_emit) begin
               if (!is_adv_ff) begin
                  emit     = 1'b1;
                  e_res    = code_ff;
                  state_in = S_IDLE;
               end else if ((k_ff == '0) && !fire_next) begin
                  emit     = 1'b1;
                  e_res    = dtq_pkg::RES_NONE_DUE;
                  e_id     = '0;
                  state_in = S_IDLE;
               end else begin
                  emit   = (k_ff != '0);
                  e_res  = dtq_pkg::RES_FIRED;
                  e_last = !fire_next;
                  if (fire_next) begin
                     new_id_in     = mem_rdata.id;
                     new_per_in    = mem_rdata.period;
                     new_dl_in     = rearm_dl;
                     place_pend_in = (mem_rdata.period != '0);
                     k_in          = k_ff + 1'b1;
                     ptr_in        = CW'(1);
                     state_in      = S_DROP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rd_addr_ff    <= rd_addr_in;
      code_ff       <= code_in;
      is_adv_ff     <= is_adv_in;
      place_pend_ff <= place_pend_in;
      now_ff        <= now_in;
      new_dl_ff     <= new_dl_in;
      new_id_ff     <= new_id_in;
      new_per_ff    <= new_per_in;
      k_ff          <= k_in;
      nstart_ff     <= nstart_in;
      if (emit) begin
         rsp_res_ff  <= e_res;
         rsp_id_ff   <= e_id;
         rsp_nv_ff   <= head_valid;
         rsp_nd_ff   <= head_dl;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.event_res     = rsp_res_ff;
   assign rsp_bus.fired_id      = rsp_id_ff;
   assign rsp_bus.next_valid    = rsp_nv_ff;
   assign rsp_bus.next_deadline = rsp_nd_ff;
   assign rsp_bus.last          = rsp_last_ff;

endmodule

/* design/deadline_timer_queue_top.sv */
// Top level of the deadline timer queue: sequencer plus slot memory.
//
// req_bus carries one request: add, cancel, update or advance time. rsp_bus
// returns one response per add, cancel or update, and one per fired timer on
// an advance (or a single "nothing due"); last marks the final response of
// a request. Each response also carries the earliest pending deadline.
// Timers live in one slot memory kept as a sorted prefix of n entries; every
// step is a read-modify-write pass through its single read and write port.
// Passes per request, n = timers pending:
//   add       insert pass from the top down; none when full
//   cancel    id scan, then shift-down pass over the rest
//   update    scan, shift down, insert pass
//   advance   per fired timer: shift down, re-arm insert
// req_bus.ready is high only while the sequencer is idle, from the cycle after
// the last response is loaded; one request is in work at a time. Responses sit
// in an output register, so a stalled receiver holds the sequencer only when
// the next response is ready to go out.
// Reset empties the queue by clearing the entry count; no clearing pass is needed.
module deadline_timer_queue_top #(
   parameter int CAPACITY = dtq_pkg::CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dtq_req_if.sink   req_bus,
   dtq_rsp_if.source rsp_bus
);

   logic                        mem_we;
   logic [$clog2(CAPACITY)-1:0] mem_waddr;
   dtq_pkg::slot_type           mem_wdata;
   logic                        mem_re;
   logic [$clog2(CAPACITY)-1:0] mem_raddr;
   dtq_pkg::slot_type           mem_rdata;

   dtq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   dtq_slot_ram #(
      .CAPACITY (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

/* verif/deadline_timer_queue_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the deadline timer queue: directed and random requests.
module deadline_timer_queue_top_test;

   localparam int KIND_W       = dtq_pkg::KIND_W;
   localparam int ID_W         = dtq_pkg::ID_W;
   localparam int DL_W         = dtq_pkg::DL_W;
   localparam int PER_W        = dtq_pkg::PER_W;
   localparam int RES_W        = dtq_pkg::RES_W;
   localparam int CAPACITY_DEF = dtq_pkg::CAPACITY_DEF;
   localparam int MAX_RESULTS  = dtq_pkg::MAX_RESULTS;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int ID_POOL = 12;

   typedef struct packed {
      logic [RES_W-1:0] event_res;
      logic [ID_W-1:0]  fired_id;
      logic             next_valid;
      logic [DL_W-1:0]  next_deadline;
      logic             last;
   } timer_rsp_type;

   class timer_scoreboard_type;
      logic [DL_W-1:0]  pend_deadline [CAPACITY_DEF];
      logic [ID_W-1:0]  pend_id [CAPACITY_DEF];
      logic [PER_W-1:0] pend_period [CAPACITY_DEF];
      int               n_pending = 0;
      timer_rsp_type    expected_rsp_q [$];
      int               mismatches = 0;

      function bit insert_timer(logic [DL_W-1:0] dl, logic [ID_W-1:0] id,
                                logic [PER_W-1:0] per);
         int pos;
         int i;
         if (n_pending >= CAPACITY_DEF) return 1'b0;
         pos = 0;
         while (pos < n_pending && pend_deadline[pos] <= dl) pos++;
         for (i = n_pending; i > pos; i--) begin
            pend_deadline[i] = pend_deadline[i-1];
            pend_id[i]       = pend_id[i-1];
            pend_period[i]   = pend_period[i-1];
         end
         pend_deadline[pos] = dl;
         pend_id[pos]       = id;
         pend_period[pos]   = per;
         n_pending++;
         return 1'b1;
      endfunction

      function void remove_timer(int pos);
         int i;
         for (i = pos; i + 1 < n_pending; i++) begin
            pend_deadline[i] = pend_deadline[i+1];
            pend_id[i]       = pend_id[i+1];
            pend_period[i]   = pend_period[i+1];
         end
         n_pending--;
      endfunction

      function int find_timer(logic [ID_W-1:0] id);
         int i;
         for (i = 0; i < n_pending; i++)
            if (pend_id[i] == id) return i;
         return -1;
      endfunction

      function void push_rsp(logic [RES_W-1:0] res, logic [ID_W-1:0] id, logic fin);
         timer_rsp_type r;
         r.event_res     = res;
         r.fired_id      = id;
         r.next_valid    = (n_pending > 0);
         r.next_deadline = (n_pending > 0) ? pend_deadline[0] : '0;
         r.last          = fin;
         expected_rsp_q.push_back(r);
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                 logic [DL_W-1:0] dl, logic [PER_W-1:0] per,
                                 logic [DL_W-1:0] now_ms);
         int pos;
         int due;
         int k;
         logic [ID_W-1:0]  fid;
         logic [PER_W-1:0] fper;
         logic [DL_W:0]    rearm;
         case (kind)
            dtq_pkg::KIND_ADD: begin
               push_rsp(insert_timer(dl, id, per) ? dtq_pkg::RES_DONE : dtq_pkg::RES_FULL,
                        id, 1'b1);
            end
            dtq_pkg::KIND_CANCEL, dtq_pkg::KIND_UPDATE: begin
               pos = find_timer(id);
               if (pos < 0) begin
                  push_rsp(dtq_pkg::RES_NOT_FOUND, id, 1'b1);
               end else begin
                  remove_timer(pos);
                  if (kind == dtq_pkg::KIND_UPDATE) void'(insert_timer(dl, id, per));
                  push_rsp(dtq_pkg::RES_DONE, id, 1'b1);
               end
            end
            default: begin
               due = 0;
               while (due < n_pending && pend_deadline[due] <= now_ms) due++;
               if (due > MAX_RESULTS) due = MAX_RESULTS;
               if (due == 0) push_rsp(dtq_pkg::RES_NONE_DUE, '0, 1'b1);
               for (k = 0; k < due; k++) begin
                  fid  = pend_id[0];
                  fper = pend_period[0];
                  remove_timer(0);
                  if (fper != 0) begin
                     rearm = {1'b0, now_ms} + {{(DL_W + 1 - PER_W){1'b0}}, fper};
                     void'(insert_timer(rearm[DL_W] ? '1 : rearm[DL_W-1:0], fid, fper));
                  end
                  push_rsp(dtq_pkg::RES_FIRED, fid, k + 1 == due);
               end
            end
         endcase
      endfunction

      function void report(string what, timer_rsp_type want, timer_rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display({"%s: expected res=%0d id=%h nv=%b nd=%h last=%b,",
                      " got res=%0d id=%h nv=%b nd=%h last=%b"},
                     what, want.event_res, want.fired_id, want.next_valid, want.next_deadline,
                     want.last, got.event_res, got.fired_id, got.next_valid,
                     got.next_deadline, got.last);
      endfunction

      function void check_response(timer_rsp_type got);
         timer_rsp_type want;
         if (expected_rsp_q.size() == 0) begin
            report("unexpected response", '0, got);
            return;
         end
         want = expected_rsp_q.pop_front();
         if (got.event_res !== want.event_res || got.fired_id !== want.fired_id ||
             got.next_valid !== want.next_valid || got.next_deadline !== want.next_deadline ||
             got.last !== want.last)
            report("response mismatch", want, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dtq_req_if req_bus ();
   dtq_rsp_if rsp_bus ();

   deadline_timer_queue_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   timer_scoreboard_type timer_sb = new();

   int send_idle_pct = 16;
   int rsp_idle_pct = 86;
   int hold_left = 0;
   int stall_cycles = 0;
   logic [DL_W-1:0] t_now = '0;
   logic [ID_W-1:0] id_pool [ID_POOL];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DL_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            timer_sb.check_response({rsp_bus.event_res, rsp_bus.fired_id, rsp_bus.next_valid,
                                     rsp_bus.next_deadline, rsp_bus.last});
         if (req_bus.valid && req_bus.ready)
            timer_sb.note_request(req_bus.kind, req_bus.tmr_id, req_bus.deadline,
                                  req_bus.repeat_period, req_bus.now);
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [DL_W-1:0] dl, input logic [PER_W-1:0] per,
                               input logic [DL_W-1:0] now_ms);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= kind;
      req_bus.tmr_id        <= id;
      req_bus.deadline      <= dl;
      req_bus.repeat_period <= per;
      req_bus.now           <= now_ms;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic run_directed();
      int i;
      send_request(dtq_pkg::KIND_ADVANCE, '0, '0, '0, '0);
      send_request(dtq_pkg::KIND_CANCEL, '1, '0, '0, '0);
      send_request(dtq_pkg::KIND_ADD, '0, '0, '0, '1);
      send_request(dtq_pkg::KIND_ADD, '1, '1, '1, '0);
      send_request(dtq_pkg::KIND_ADD, 32'd7, 48'd100, '0, '0);
      // duplicate id at an equal deadline
      send_request(dtq_pkg::KIND_ADD, 32'd7, 48'd100, 32'd50, '0);
      send_request(dtq_pkg::KIND_CANCEL, 32'd7, '0, '0, '0);
      send_request(dtq_pkg::KIND_UPDATE, 32'd7, '0, 32'd10, '0);
      send_request(dtq_pkg::KIND_ADVANCE, '0, '0, '0, '0);
      // re-arm saturates at the top of the time range
      send_request(dtq_pkg::KIND_ADVANCE, '0, '0, '0, '1);
      send_request(dtq_pkg::KIND_CANCEL, '1, '0, '0, '0);
      send_request(dtq_pkg::KIND_UPDATE, 32'd7, 48'd5, '0, '0);
      for (i = 0; i < CAPACITY_DEF - 1; i++)
         send_request(dtq_pkg::KIND_ADD, 32'(i + 1) * 32'h1111_1111, 48'(45 - 3 * i),
                      PER_W'(i % 2), '0);
      send_request(dtq_pkg::KIND_ADD, 32'hDEAD_0001, 48'd1, '0, '0);
      // every slot due: the most responses one request can produce
      send_request(dtq_pkg::KIND_ADVANCE, '0, '0, '0, 48'd1000);
      t_now = 48'd1000;
   endtask

   task automatic run_random(input int count);
      int i;
      int pick;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [DL_W-1:0]   dl;
      logic [PER_W-1:0]  per;
      logic [DL_W-1:0]   now_ms;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(ID_POOL - 1)] : $urandom;
         dl = ($urandom_range(19) == 0) ? rand48() : t_now + DL_W'($urandom_range(60));
         case ($urandom_range(19))
            0:             per = $urandom;
            1,2,3,4,5,6,7: per = $urandom_range(1, 40);
            default:       per = '0;
         endcase
         now_ms = rand48();
         if (pick < 35) begin
            kind = dtq_pkg::KIND_ADD;
         end else if (pick < 50) begin
            kind = dtq_pkg::KIND_CANCEL;
         end else if (pick < 65) begin
            kind = dtq_pkg::KIND_UPDATE;
         end else begin
            kind = dtq_pkg::KIND_ADVANCE;
            if ($urandom_range(19) != 0) now_ms = t_now + DL_W'($urandom_range(40));
            t_now = now_ms;
         end
         send_request(kind, id, dl, per, now_ms);
      end
   endtask

   initial begin
      int i;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= dtq_pkg::KIND_ADD;
      req_bus.tmr_id        <= '0;
      req_bus.deadline      <= '0;
      req_bus.repeat_period <= '0;
      req_bus.now           <= '0;
      for (i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      rsp_idle_pct  = 86;
      run_directed();
      run_random(70);

      send_idle_pct = 86;
      rsp_idle_pct  = 16;
      run_random(70);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_left     = 300;
      run_random(70);

      req_bus.valid <= 1'b0;
      while (timer_sb.expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (timer_sb.mismatches == 0 && timer_sb.expected_rsp_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
design/dtq_pkg.sv
design/dtq_if.sv
design/dtq_slot_ram.sv
design/dtq_ctrl.sv
design/deadline_timer_queue_top.sv
verif/deadline_timer_queue_top_test.sv
